// ----- rtl/core/nlmf_pkg.sv -----
// Shared constants and types for the literal match finder.
package nlmf_pkg;

  localparam int PATTERN_MAX = 8;
  localparam int OFFSET_BITS = 32;
  localparam int PAT_BYTES   = 8;
  localparam int PAT_IDX_W   = 3;
  localparam int LEN_W       = 4;
  localparam int LIMIT_W     = 16;
  localparam int POS_W       = 32;
  localparam int CFG_W       = 64;
  localparam int CFG_IDX_W   = 2;
  localparam int STATUS_W    = 2;
  localparam int AGE_W       = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;

  localparam logic [LEN_W-1:0]   LEN_RESET   = LEN_W'(1);
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(256);

  typedef logic [PAT_BYTES-1:0][7:0] pattern_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PATTERN_BYTES = 2'd0,
    REG_PAT_LEN       = 2'd1,
    REG_MATCH_LIMIT   = 2'd2
  } cfg_reg_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK       = 2'd0,
    STATUS_TOO_MANY = 2'd1,
    STATUS_EMPTY    = 2'd2
  } status_t;

  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctrl_t;

endpackage

// ----- rtl/core/nlmf_if.sv -----
// Handshake interfaces for text beats and result beats.
interface nlmf_text_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       last_byte;

  modport source (output valid, text_byte, last_byte, input ready);
  modport sink (input valid, text_byte, last_byte, output ready);
endinterface

interface nlmf_result_if;
  logic        valid;
  logic        ready;
  logic        match_found;
  logic [31:0] match_start;
  logic [31:0] match_end;
  logic        end_of_text;
  logic [1:0]  search_status;

  modport source (output valid, match_found, match_start, match_end, end_of_text,
                  search_status, input ready);
  modport sink (input valid, match_found, match_start, match_end, end_of_text,
                search_status, output ready);
endinterface

// ----- rtl/core/nlmf_cell.sv -----
// One history cell: holds one past byte and compares its input against the pattern.
module nlmf_cell
  import nlmf_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic [AGE_W-1:0] age,
  input  pattern_t         pattern,
  input  logic [LEN_W-1:0] pat_len,
  input  cell_ctrl_t       ctrl,
  input  logic [7:0]       byte_in,
  output logic [7:0]       byte_out,
  output logic             pass
);

  logic [7:0]       byte_q;
  logic [LEN_W-1:0] age_ext;
  logic [LEN_W-1:0] idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_q <= '0;
    end else if (ctrl.shift) begin
      byte_q <= ctrl.clear ? 8'd0 : byte_in;
    end
  end

  assign age_ext  = LEN_W'(age);
  assign idx      = pat_len - age_ext - LEN_W'(1);
  assign pass     = (age_ext >= pat_len) ||
                    (byte_in == pattern[idx[PAT_IDX_W-1:0]]);
  assign byte_out = byte_q;

endmodule

// ----- rtl/core/nonoverlap_literal_match_finder_unit.sv -----
// Top level of the non-overlapping literal match finder.
// Takes one text beat per cycle and answers it from a registered result stage;
// a new text beat is taken whenever that stage is empty or being drained in the same cycle, so
// the sustained rate is one byte per clock. A row of PATTERN_MAX cells shifts the recent bytes
// and compares every pattern position in parallel, and a single offset compare decides whether
// the candidate starts past the previous match. A result beat comes for each reported match and
// for every byte marked last, which also clears the history and counters for the next text.
module nonoverlap_literal_match_finder_unit
  import nlmf_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  nlmf_text_if.sink            text,
  nlmf_result_if.source        result,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  pattern_t               pattern_bytes;
  logic [LEN_W-1:0]       pat_len;
  logic [LIMIT_W-1:0]     match_limit;

  logic [OFFSET_BITS-1:0] byte_offset;
  logic [OFFSET_BITS-1:0] next_allowed_start;
  logic [LIMIT_W-1:0]     match_count;
  logic                   overflowed;

  logic                   out_valid;
  logic                   out_found;
  logic [POS_W-1:0]       out_start;
  logic [POS_W-1:0]       out_end;
  logic                   out_eot;
  status_t                out_status;

  logic                   accept;
  cell_ctrl_t             ctrl;
  logic [7:0]             chain [PATTERN_MAX+1];
  logic [PATTERN_MAX-1:0] pass;

  logic [OFFSET_BITS:0]   p1;
  logic [OFFSET_BITS:0]   s_wide;
  logic [OFFSET_BITS-1:0] s;
  logic                   len_ok;
  logic                   cand;
  logic                   hit;
  logic                   over_set;
  status_t                status;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_bytes <= '0;
      pat_len       <= LEN_RESET;
      match_limit   <= LIMIT_RESET;
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        REG_PATTERN_BYTES: pattern_bytes <= pattern_t'(cfg_data);
        REG_PAT_LEN:       pat_len       <= cfg_data[LEN_W-1:0];
        REG_MATCH_LIMIT:   match_limit   <= cfg_data[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  assign accept     = text.valid && text.ready;
  assign text.ready = !out_valid || result.ready;
  assign ctrl.shift = accept;
  assign ctrl.clear = text.last_byte;
  assign chain[0]   = text.text_byte;

  for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_cell
    nlmf_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .age      (AGE_W'(k)),
      .pattern  (pattern_bytes),
      .pat_len  (pat_len),
      .ctrl     (ctrl),
      .byte_in  (chain[k]),
      .byte_out (chain[k+1]),
      .pass     (pass[k])
    );
  end

  assign p1       = {1'b0, byte_offset} + (OFFSET_BITS+1)'(1);
  assign s_wide   = p1 - (OFFSET_BITS+1)'(pat_len);
  assign s        = s_wide[OFFSET_BITS-1:0];
  assign len_ok   = (pat_len != '0) && (pat_len <= LEN_W'(PATTERN_MAX));
  assign cand     = len_ok && !overflowed && (p1 >= (OFFSET_BITS+1)'(pat_len)) &&
                    (s_wide >= {1'b0, next_allowed_start}) && (&pass);
  assign hit      = cand && (match_count < match_limit);
  assign over_set = cand && (match_count >= match_limit);

  always_comb begin
    if (pat_len == '0) begin
      status = STATUS_EMPTY;
    end else if (overflowed || over_set) begin
      status = STATUS_TOO_MANY;
    end else begin
      status = STATUS_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_offset        <= '0;
      next_allowed_start <= '0;
      match_count        <= '0;
      overflowed         <= 1'b0;
    end else if (accept) begin
      if (text.last_byte) begin
        byte_offset        <= '0;
        next_allowed_start <= '0;
        match_count        <= '0;
        overflowed         <= 1'b0;
      end else begin
        byte_offset <= p1[OFFSET_BITS-1:0];
        if (hit) begin
          match_count        <= match_count + LIMIT_W'(1);
          next_allowed_start <= p1[OFFSET_BITS-1:0];
        end
        if (over_set) begin
          overflowed <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= hit || text.last_byte;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_found  <= hit;
      out_start  <= hit ? POS_W'(s) : '0;
      out_end    <= hit ? POS_W'(p1) : '0;
      out_eot    <= text.last_byte;
      out_status <= text.last_byte ? status : STATUS_OK;
    end
  end

  assign result.valid         = out_valid;
  assign result.match_found   = out_found;
  assign result.match_start   = out_start;
  assign result.match_end     = out_end;
  assign result.end_of_text   = out_eot;
  assign result.search_status = out_status;

endmodule

// ----- rtl/core/nlmf_checker.sv -----
// Port-level checks for the literal match finder and their attachment to the top level.
module nlmf_checker
  import nlmf_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        text_ready,
  input logic        res_valid,
  input logic        res_ready,
  input logic        res_found,
  input logic [31:0] res_start,
  input logic [31:0] res_end,
  input logic        res_eot,
  input logic [1:0]  res_status
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("Result beat shown right after reset.");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_found) && $stable(res_start) &&
    $stable(res_end) && $stable(res_eot) && $stable(res_status))
    else $error("Stalled result beat changed.");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !res_valid |-> text_ready)
    else $error("Text side stalled while the result stage is empty.");

  a_no_match_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_found |-> res_start == 32'd0 && res_end == 32'd0)
    else $error("Offsets given without a match.");

  a_mid_text_is_match: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_eot |-> res_found && res_status == STATUS_OK)
    else $error("Result beat inside a text carries no match or a status.");

endmodule

bind nonoverlap_literal_match_finder_unit nlmf_checker u_nlmf_checker (
  .clk        (clk),
  .rst        (rst),
  .text_ready (text.ready),
  .res_valid  (result.valid),
  .res_ready  (result.ready),
  .res_found  (result.match_found),
  .res_start  (result.match_start),
  .res_end    (result.match_end),
  .res_eot    (result.end_of_text),
  .res_status (result.search_status)
);
